// ===== src/tacld_pkg.sv =====
// Shared types, codes and helpers for the three-axis calibrate / limit detect core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package tacld_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned CAL_W      = 16;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned PROD_W     = SAMPLE_W + 1 + GAIN_W + 1;
  localparam int unsigned FRAC_SHIFT = 8;
  localparam int unsigned Q_W        = PROD_W - FRAC_SHIFT;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

  typedef enum logic [0:0] {
    OP_PUSH    = 1'b0,
    OP_PUBLISH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_MAG = 2'd3
  } axis_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X    = 3'd0,
    REG_OFFSET_Y    = 3'd1,
    REG_OFFSET_Z    = 3'd2,
    REG_GAIN_X      = 3'd3,
    REG_GAIN_Y      = 3'd4,
    REG_GAIN_Z      = 3'd5,
    REG_AXIS_LIMITS = 3'd6,
    REG_MAG_LIMIT   = 3'd7
  } cfg_reg_t;

  // Per-axis calibration coefficients.
  typedef struct packed {
    logic [NUM_AXES-1:0][SAMPLE_W-1:0] offset;
    logic [NUM_AXES-1:0][GAIN_W-1:0]   gain;
  } cal_cfg_t;

  // Push command into the calibration unit.
  typedef struct packed {
    logic                valid;
    axis_t               axis;
    logic [SAMPLE_W-1:0] sample;
  } push_t;

  // Registered publish stage: values, squares, axis hits, squared magnitude limit.
  typedef struct packed {
    logic [NUM_AXES-1:0][CAL_W-1:0] cal;
    logic [NUM_AXES-1:0][SQ_W-1:0]  sq;
    logic [NUM_AXES-1:0]            hit;
    logic [SQ_W-1:0]                mlim_sq;
    logic                           mlim_nz;
  } stats_t;

  // Clamp a shifted product into signed 16 bits.
  function automatic logic [CAL_W-1:0] sat16(input logic signed [Q_W-1:0] q);
    logic [CAL_W-1:0] r;
    if (q > $signed({{(Q_W-CAL_W+1){1'b0}}, {(CAL_W-1){1'b1}}})) begin
      r = {1'b0, {(CAL_W-1){1'b1}}};
    end else if (q < $signed({{(Q_W-CAL_W+1){1'b1}}, {(CAL_W-1){1'b0}}})) begin
      r = {1'b1, {(CAL_W-1){1'b0}}};
    end else begin
      r = q[CAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/tacld_calib.sv =====
// Calibration unit: (sample - offset) * gain >> 8, saturated, into per-axis pending values.
// Depends on tacld_pkg.
`timescale 1ns / 1ps

module tacld_calib
  import tacld_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  push_t                          push,
  input  cal_cfg_t                       cfg,
  output logic [NUM_AXES-1:0][CAL_W-1:0] pending
);

  logic [1:0]              sel;
  logic [SAMPLE_W-1:0]     off;
  logic [GAIN_W-1:0]       gain;
  logic signed [SAMPLE_W:0] diff;
  logic signed [GAIN_W:0]  gain_s;
  logic signed [PROD_W-1:0] prod;
  logic [CAL_W-1:0]        value_next;

  always_comb begin
    // magnitude pseudo-axis never writes; keep the index in range anyway
    sel        = (push.axis == AXIS_MAG) ? 2'd0 : push.axis;
    off        = cfg.offset[sel];
    gain       = cfg.gain[sel];
    diff       = $signed({push.sample[SAMPLE_W-1], push.sample})
               - $signed({off[SAMPLE_W-1], off});
    gain_s     = $signed({1'b0, gain});
    prod       = PROD_W'(diff) * PROD_W'(gain_s);
    // arithmetic shift: floor toward minus infinity
    value_next = sat16(prod[PROD_W-1:FRAC_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (push.valid && push.axis != AXIS_MAG) begin
      pending[sel] <= value_next;
    end
  end

endmodule

// ===== src/tacld_stats.sv =====
// Publish stage: squares of the pending values, per-axis limit hits, squared magnitude limit.
// Depends on tacld_pkg.
`timescale 1ns / 1ps

module tacld_stats
  import tacld_pkg::*;
(
  input  logic                           clk,
  input  logic                           load,
  input  logic [NUM_AXES-1:0][CAL_W-1:0] pending,
  input  logic [CFG_DATA_W-1:0]          axis_limits,
  input  logic [LIMIT_W-1:0]             mag_limit,
  output stats_t                         stats
);

  stats_t              stats_next;
  logic signed [CAL_W:0] v_ext;
  logic [CAL_W:0]      v_abs;
  logic [LIMIT_W-1:0]  lim;
  logic signed [SQ_W-1:0] sq_s;

  always_comb begin
    stats_next = '0;
    v_ext      = '0;
    v_abs      = '0;
    lim        = '0;
    sq_s       = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      v_ext = $signed({pending[i][CAL_W-1], pending[i]});
      v_abs = v_ext[CAL_W] ? $unsigned(-v_ext) : $unsigned(v_ext);
      lim   = axis_limits[i*LIMIT_W +: LIMIT_W];
      sq_s  = SQ_W'($signed(pending[i])) * SQ_W'($signed(pending[i]));
      stats_next.cal[i] = pending[i];
      stats_next.sq[i]  = $unsigned(sq_s);
      // |v| >= lim is the same test as v^2 >= lim^2
      stats_next.hit[i] = (lim != '0) && (v_abs >= {1'b0, lim});
    end
    stats_next.mlim_sq = SQ_W'(mag_limit) * SQ_W'(mag_limit);
    stats_next.mlim_nz = (mag_limit != '0);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stats <= stats_next;
    end
  end

endmodule

// ===== src/three_axis_calibrate_limit_detect_core.sv =====
// Top level of the three-axis calibrate / limit detect core.
// Depends on tacld_pkg, tacld_calib and tacld_stats.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_axis_*): tuser carries the op (push / publish) and axis,
//   tdata the raw signed sample. A push calibrates one axis into its pending
//   Q8.8 value and produces no output; a push for the magnitude axis is dropped.
//   A publish produces one output item with the three pending values, their
//   squared sum (Q16.16) and four limit flags.
//   Output stream (m_axis_*): one item per publish, in order.
//   Config port: cfg_we / cfg_index / cfg_data, one register per write,
//   applied at the clock edge; write only while the core is idle.
// Timing
//   Input register, calibrate or square stage, output register. A publish
//   passes the input register and square stage into the output register
//   (m_axis_tvalid); a push updates its pending value the cycle after it is
//   accepted, so a publish right behind it sees it. Throughput is one item per
//   cycle unless the output stalls; calibrate multiplier and squarers are combinational.
// Reset / stall
//   rst (synchronous) clears pending values, pipeline valids and all config
//   registers (gains to 65536). When m_axis_tready is low, the output holds and
//   stages behind it keep filling; s_axis_tready drops only once a publish
//   waits in the input register with the square stage full.
module three_axis_calibrate_limit_detect_core
  import tacld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // [15:0] sample
  input  logic [2:0]            s_axis_tuser,  // [0] op, [2:1] axis
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [87:0]           m_axis_tdata,  // [15:0] cal_x, [31:16] cal_y, [47:32] cal_z,
                                               // [79:48] mag_squared, [80] hit_x, [81] hit_y,
                                               // [82] hit_z, [83] hit_magnitude, [87:84] zero
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  cal_cfg_t                cal_cfg;
  logic [CFG_DATA_W-1:0]   axis_limits;
  logic [LIMIT_W-1:0]      mag_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_cfg.offset <= '0;
      cal_cfg.gain   <= {NUM_AXES{GAIN_RESET}};
      axis_limits    <= '0;
      mag_limit      <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_OFFSET_X:    cal_cfg.offset[0] <= cfg_data[SAMPLE_W-1:0];
        REG_OFFSET_Y:    cal_cfg.offset[1] <= cfg_data[SAMPLE_W-1:0];
        REG_OFFSET_Z:    cal_cfg.offset[2] <= cfg_data[SAMPLE_W-1:0];
        REG_GAIN_X:      cal_cfg.gain[0]   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_Y:      cal_cfg.gain[1]   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_Z:      cal_cfg.gain[2]   <= cfg_data[GAIN_W-1:0];
        REG_AXIS_LIMITS: axis_limits       <= cfg_data;
        REG_MAG_LIMIT:   mag_limit         <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshakes: each stage moves when the one after it is empty or moving
  logic                in_valid;
  op_t                 in_op;
  axis_t               in_axis;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_ready;
  logic                in_leave;
  logic                sq_valid;
  logic                sq_ready;
  logic                sq_load;
  logic                out_ready;
  logic                out_load;

  assign out_ready = !m_axis_tvalid || m_axis_tready;
  assign sq_ready  = !sq_valid || out_ready;
  // pushes retire in the input stage; only publishes need the square stage
  assign in_leave  = in_valid && (in_op == OP_PUSH || sq_ready);
  assign in_ready  = !in_valid || in_leave;
  assign sq_load   = in_valid && in_op == OP_PUBLISH && sq_ready;
  assign out_load  = sq_valid && out_ready;

  assign s_axis_tready = in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= (in_valid && !in_leave) || (s_axis_tvalid && in_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && in_ready) begin
      in_op     <= op_t'(s_axis_tuser[0]);
      in_axis   <= axis_t'(s_axis_tuser[2:1]);
      in_sample <= s_axis_tdata;
    end
  end

  // calibration and pending values
  push_t                          push;
  logic [NUM_AXES-1:0][CAL_W-1:0] pending;

  always_comb begin
    push.valid  = in_valid && in_op == OP_PUSH;
    push.axis   = in_axis;
    push.sample = in_sample;
  end

  tacld_calib u_calib (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cfg     (cal_cfg),
    .pending (pending)
  );

  // square stage
  stats_t stats;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= sq_load || (sq_valid && !out_ready);
    end
  end

  tacld_stats u_stats (
    .clk         (clk),
    .load        (sq_load),
    .pending     (pending),
    .axis_limits (axis_limits),
    .mag_limit   (mag_limit),
    .stats       (stats)
  );

  // sum and magnitude compare, then output register
  logic [SQ_W-1:0] mag_sq_next;
  logic            hit_mag_next;
  logic [SQ_W-1:0] mag_sq;
  logic [NUM_AXES-1:0][CAL_W-1:0] res_cal;
  logic [NUM_AXES-1:0] res_hit;
  logic            res_hit_mag;

  // squares are at most 2^30 each, so the sum fits in 32 bits
  assign mag_sq_next  = stats.sq[0] + stats.sq[1] + stats.sq[2];
  assign hit_mag_next = stats.mlim_nz && (mag_sq_next >= stats.mlim_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= out_load || (m_axis_tvalid && !m_axis_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_cal     <= stats.cal;
      mag_sq      <= mag_sq_next;
      res_hit     <= stats.hit;
      res_hit_mag <= hit_mag_next;
    end
  end

  assign m_axis_tdata = {4'b0000, res_hit_mag, res_hit[2], res_hit[1], res_hit[0],
                         mag_sq, res_cal[2], res_cal[1], res_cal[0]};

  // checks
  a_sq_to_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_axis_tvalid)
    else $error("square stage item did not reach the output register");

  a_push_no_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && in_op == OP_PUBLISH && sq_valid && !out_ready)
    else $error("input stalled without a blocked publish");

  a_hit_x_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_hit[0] |-> axis_limits[LIMIT_W-1:0] != '0)
    else $error("x hit with x limit disabled");

  a_hit_mag_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_hit_mag |-> mag_limit != '0 && mag_sq != '0)
    else $error("magnitude hit with magnitude limit disabled");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for three_axis_calibrate_limit_detect_core.
// Tracks pending per-axis Q8.8 values and config internally, checks each published reading.
// Depends on tacld_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top
  import tacld_pkg::*;
();

  // one input item: op and axis go out on tuser, the raw sample on tdata
  typedef struct {
    op_t         op;
    axis_t       axis;
    logic [15:0] sample;
  } cmd_t;

  // one published reading, field for field as packed on m_axis_tdata
  typedef struct {
    logic [15:0] cal_x;
    logic [15:0] cal_y;
    logic [15:0] cal_z;
    logic [31:0] mag_sq;
    logic        hit_x;
    logic        hit_y;
    logic        hit_z;
    logic        hit_mag;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;   // [15:0] sample
  logic [2:0]            s_axis_tuser = '0;   // [0] op, [2:1] axis
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [87:0]           m_axis_tdata;        // cal_x, cal_y, cal_z, mag_squared, 4 hit flags
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  three_axis_calibrate_limit_detect_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the core: config registers and the three pending values
  // ---------------------------------------------------------------------------
  logic [15:0] cal_offset [3];
  logic [23:0] cal_gain [3];
  logic [47:0] cfg_axis_lim;
  logic [15:0] cfg_mag_lim;
  logic [15:0] cal_pending [3];

  cmd_t     cmd_backlog [$];   // items waiting for the driver
  reading_t readings_due [$];  // readings owed by the core, oldest first
  int       mismatches = 0;

  // (raw - offset) * gain, floor of /256, clamp to signed 16
  function automatic logic [15:0] calibrate_raw(logic [15:0] raw, logic [15:0] off,
                                                logic [23:0] gain);
    longint q;
    q = ((longint'($signed(raw)) - longint'($signed(off))) * longint'(gain)) >>> 8;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Advance the shadow by one accepted item; a publish owes one reading.
  task automatic track_item(input cmd_t c);
    reading_t r;
    longint   v, sq, lim, sum, mlim;
    logic     hit [3];
    if (c.op == OP_PUSH) begin
      // magnitude axis push is dropped
      if (c.axis != AXIS_MAG)
        cal_pending[c.axis] = calibrate_raw(c.sample, cal_offset[c.axis], cal_gain[c.axis]);
    end else begin
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        v   = longint'($signed(cal_pending[i]));
        sq  = v * v;
        lim = longint'(cfg_axis_lim[16*i +: 16]);
        hit[i] = (lim != 0) && (sq >= lim * lim);  // zero limit = check off
        sum += sq;
      end
      mlim      = longint'(cfg_mag_lim);
      r.cal_x   = cal_pending[0];
      r.cal_y   = cal_pending[1];
      r.cal_z   = cal_pending[2];
      r.mag_sq  = sum[31:0];
      r.hit_x   = hit[0];
      r.hit_y   = hit[1];
      r.hit_z   = hit[2];
      r.hit_mag = (mlim != 0) && (sum >= mlim * mlim);
      readings_due.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idle pattern: mostly short gaps, a few long ones, and calm stretches
  // with no gaps at all
  // ---------------------------------------------------------------------------
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers backlog items, tracks each one as it is accepted
  // ---------------------------------------------------------------------------
  cmd_t cur_cmd;
  int   src_gap = 0;
  int   src_mode_left = 0;
  bit   src_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap       = 0;
    end else begin
      if (src_mode_left == 0) begin
        src_calm      = ($urandom_range(0, 3) == 0);
        src_mode_left = $urandom_range(20, 200);
      end else begin
        src_mode_left--;
      end
      if (s_axis_tvalid && s_axis_tready) track_item(cur_cmd);
      // new item only once the current one is gone
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          cur_cmd       = cmd_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_cmd.sample;
          s_axis_tuser  <= {cur_cmd.axis, cur_cmd.op};
          src_gap       = pick_gap(src_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, long hold-offs on request, reading check
  // ---------------------------------------------------------------------------
  int snk_gap = 0;
  int snk_mode_left = 0;
  bit snk_calm = 1'b0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_served = 0;
  bit hold_on = 1'b0;

  // long hold-off counter; the monitor only looks at hold_on
  always @(posedge clk) begin
    if (rst) begin
      hold_left = 0;
      hold_on  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      hold_on <= 1'b1;
    end else if (holds_served < holds_asked) begin
      // lets the pipeline fill and stall the input side
      holds_served++;
      hold_left = 400;
      hold_on  <= 1'b1;
    end else begin
      hold_on <= 1'b0;
    end
  end

  function automatic reading_t unpack_reading(logic [87:0] d);
    reading_t r;
    r.cal_x   = d[15:0];
    r.cal_y   = d[31:16];
    r.cal_z   = d[47:32];
    r.mag_sq  = d[79:48];
    r.hit_x   = d[80];
    r.hit_y   = d[81];
    r.hit_z   = d[82];
    r.hit_mag = d[83];
    return r;
  endfunction

  task automatic check_reading(input logic [87:0] d);
    reading_t got, want;
    got = unpack_reading(d);
    if (readings_due.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: reading with none owed: x=%h y=%h z=%h mag=%h hits=%b%b%b%b",
                 $realtime, got.cal_x, got.cal_y, got.cal_z, got.mag_sq,
                 got.hit_mag, got.hit_z, got.hit_y, got.hit_x);
      mismatches++;
    end else begin
      want = readings_due.pop_front();
      if (got.cal_x != want.cal_x || got.cal_y != want.cal_y || got.cal_z != want.cal_z ||
          got.mag_sq != want.mag_sq || got.hit_x != want.hit_x || got.hit_y != want.hit_y ||
          got.hit_z != want.hit_z || got.hit_mag != want.hit_mag) begin
        if (mismatches < 10) begin
          $display("%0t: reading mismatch", $realtime);
          $display("  exp x=%h y=%h z=%h mag=%h hit mxyz=%b%b%b%b", want.cal_x, want.cal_y,
                   want.cal_z, want.mag_sq, want.hit_mag, want.hit_x, want.hit_y, want.hit_z);
          $display("  got x=%h y=%h z=%h mag=%h hit mxyz=%b%b%b%b", got.cal_x, got.cal_y,
                   got.cal_z, got.mag_sq, got.hit_mag, got.hit_x, got.hit_y, got.hit_z);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (snk_mode_left == 0) begin
        snk_calm      = ($urandom_range(0, 3) == 0);
        snk_mode_left = $urandom_range(20, 200);
      end else begin
        snk_mode_left--;
      end
      if (m_axis_tvalid && m_axis_tready) check_reading(m_axis_tdata);
      if (hold_on) begin
        m_axis_tready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ((m_axis_tvalid && m_axis_tready) || $urandom_range(0, 5) == 0)
          snk_gap = pick_gap(snk_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic cmd_t mk_cmd(op_t op, axis_t axis, logic [15:0] sample);
    cmd_t c;
    c.op     = op;
    c.axis   = axis;
    c.sample = sample;
    return c;
  endfunction

  // Mostly pushes to x/y/z, some magnitude pushes, ~30% publishes.
  // Samples: full range mostly, near zero sometimes.
  function automatic cmd_t random_cmd();
    logic [15:0] s;
    s = ($urandom_range(0, 3) == 0) ? 16'($signed($urandom_range(0, 1024)) - 512)
                                    : 16'($urandom);
    if ($urandom_range(0, 99) < 30)
      return mk_cmd(OP_PUBLISH, axis_t'($urandom_range(0, 3)), s);
    return mk_cmd(OP_PUSH, ($urandom_range(0, 9) == 0) ? AXIS_MAG
                                                      : axis_t'($urandom_range(0, 2)), s);
  endfunction

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return GAIN_RESET;
      3:       return 24'($urandom_range(0, 1024));
      4:       return 24'($urandom_range(0, 131072));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 16'h2000));
      3:       return 16'($urandom_range(16'h4000, 16'hB600));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [47:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OFFSET_X:    cal_offset[0] = val[15:0];
      REG_OFFSET_Y:    cal_offset[1] = val[15:0];
      REG_OFFSET_Z:    cal_offset[2] = val[15:0];
      REG_GAIN_X:      cal_gain[0]   = val[23:0];
      REG_GAIN_Y:      cal_gain[1]   = val[23:0];
      REG_GAIN_Z:      cal_gain[2]   = val[23:0];
      REG_AXIS_LIMITS: cfg_axis_lim  = val;
      REG_MAG_LIMIT:   cfg_mag_lim   = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [15:0] ox, oy, oz, input logic [23:0] gx, gy, gz,
                             input logic [47:0] alim, input logic [15:0] mlim);
    write_reg(REG_OFFSET_X, {32'h0, ox});
    write_reg(REG_OFFSET_Y, {32'h0, oy});
    write_reg(REG_OFFSET_Z, {32'h0, oz});
    write_reg(REG_GAIN_X, {24'h0, gx});
    write_reg(REG_GAIN_Y, {24'h0, gy});
    write_reg(REG_GAIN_Z, {24'h0, gz});
    write_reg(REG_AXIS_LIMITS, alim);
    write_reg(REG_MAG_LIMIT, {32'h0, mlim});
  endtask

  // Wait until every item is in and every reading is out, then let the
  // pipeline (3 stages) run empty so no push is still on its way.
  task automatic settle();
    while (cmd_backlog.size() != 0 || s_axis_tvalid || readings_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      cal_offset[i]  = '0;
      cal_gain[i]    = GAIN_RESET;
      cal_pending[i] = '0;
    end
    cfg_axis_lim = '0;
    cfg_mag_lim  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset config (unity gain, no offset, checks off) ---
    // publish before any push: reset zeros; axis and sample ignored on publish
    cmd_backlog.push_back(mk_cmd(OP_PUBLISH, AXIS_MAG, 16'hFFFF));
    cmd_backlog.push_back(mk_cmd(OP_PUSH, AXIS_X, 16'h7FFF));
    cmd_backlog.push_back(mk_cmd(OP_PUSH, AXIS_Y, 16'h8000));
    cmd_backlog.push_back(mk_cmd(OP_PUSH, AXIS_Z, 16'h0000));
    cmd_backlog.push_back(mk_cmd(OP_PUBLISH, AXIS_X, 16'h0000));
    // magnitude axis push must leave everything alone
    cmd_backlog.push_back(mk_cmd(OP_PUSH, AXIS_MAG, 16'h1234));
    cmd_backlog.push_back(mk_cmd(OP_PUBLISH, AXIS_Z, 16'h5A5A));
    cmd_backlog.push_back(mk_cmd(OP_PUSH, AXIS_X, 16'hFFFF));
    cmd_backlog.push_back(mk_cmd(OP_PUSH, AXIS_Y, 16'h0001));
    cmd_backlog.push_back(mk_cmd(OP_PUSH, AXIS_Z, 16'h8000));
    cmd_backlog.push_back(mk_cmd(OP_PUBLISH, AXIS_Y, 16'h8000));
    settle();

    // --- directed, extreme config: zero gain on x, max gain on y, gain 0x100 on z,
    //     offsets at both ends, tight z limit, max magnitude limit ---
    load_config(16'h7FFF, 16'h8000, 16'h1234, 24'h000000, 24'hFFFFFF, 24'h000100,
                {16'h0001, 16'hFFFF, 16'h0080}, 16'hFFFF);
    cmd_backlog.push_back(mk_cmd(OP_PUSH, AXIS_X, 16'h8000));  // zero gain -> 0
    cmd_backlog.push_back(mk_cmd(OP_PUSH, AXIS_Y, 16'h7FFF));  // saturates high
    cmd_backlog.push_back(mk_cmd(OP_PUSH, AXIS_Z, 16'h8000));  // saturates low
    cmd_backlog.push_back(mk_cmd(OP_PUBLISH, AXIS_X, 16'h0000));
    cmd_backlog.push_back(mk_cmd(OP_PUSH, AXIS_Y, 16'h8000));  // diff zero
    cmd_backlog.push_back(mk_cmd(OP_PUSH, AXIS_Z, 16'h7FFF));
    cmd_backlog.push_back(mk_cmd(OP_PUBLISH, AXIS_MAG, 16'h7FFF));
    cmd_backlog.push_back(mk_cmd(OP_PUSH, AXIS_Z, 16'h1235));  // z = 1, at its limit
    cmd_backlog.push_back(mk_cmd(OP_PUBLISH, AXIS_Z, 16'h0000));
    settle();

    // --- random phases, new register settings each time ---
    for (int p = 0; p < 6; p++) begin
      if (p == 0)
        load_config(16'h8000, 16'h7FFF, 16'h8000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                    48'hFFFF_FFFF_FFFF, 16'hFFFF);
      else if (p == 1)
        load_config(16'h0000, 16'h0000, 16'h0000, 24'h000000, 24'h000000, 24'h000000,
                    48'h0, 16'h0000);
      else
        load_config(pick_offset(), pick_offset(), pick_offset(),
                    pick_gain(), pick_gain(), pick_gain(),
                    {pick_limit(), pick_limit(), pick_limit()}, pick_limit());
      for (int n = 0; n < 300; n++) cmd_backlog.push_back(random_cmd());
      // stall the output for a long stretch while items keep coming
      if (p == 2 || p == 4) holds_asked++;
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/tacld_pkg.sv
src/tacld_calib.sv
src/tacld_stats.sv
src/three_axis_calibrate_limit_detect_core.sv
tb/tb_top.sv
